>>> hw/rtl/track_order_sequencer_unit_assert.svh
// ---------------------------------------------------------------------------
// track order sequencer assertion macros
// shared concurrent check forms, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef TRACK_ORDER_SEQUENCER_UNIT_ASSERT_SVH
`define TRACK_ORDER_SEQUENCER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TOSU_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tosu: same-cycle check failed");

// next-cycle implication
`define TOSU_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tosu: next-cycle check failed");

`else

`define TOSU_ASSERT_IMPLY(name, clk, rstn, ante, cons)
`define TOSU_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/tosu_pkg.sv
// ---------------------------------------------------------------------------
// tosu_pkg
// codes and control types shared by the track order sequencer modules
// ---------------------------------------------------------------------------
`default_nettype none

package tosu_pkg;

    // event codes
    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_PICK   = 3'd1;
    localparam logic [2:0] MODE_NEXT   = 3'd2;
    localparam logic [2:0] MODE_PREV   = 3'd3;
    localparam logic [2:0] MODE_EOT    = 3'd4;
    localparam logic [2:0] MODE_STOP   = 3'd5;

    // result actions
    localparam logic [1:0] ACT_OPEN = 2'd0;
    localparam logic [1:0] ACT_STOP = 2'd1;
    localparam logic [1:0] ACT_NONE = 2'd2;

    // repeat modes
    localparam logic [1:0] REP_OFF = 2'd0;
    localparam logic [1:0] REP_ONE = 2'd1;
    localparam logic [1:0] REP_ALL = 2'd2;
    localparam logic [1:0] REP_BAD = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_REPEAT  = 2'd0;
    localparam logic [1:0] CFG_SHUFFLE = 2'd1;
    localparam logic [1:0] CFG_LIBRARY = 2'd2;

    // how the next track is found
    localparam logic [1:0] ROUTE_DIRECT    = 2'd0;
    localparam logic [1:0] ROUTE_READ      = 2'd1;
    localparam logic [1:0] ROUTE_DIV_QUEUE = 2'd2;
    localparam logic [1:0] ROUTE_DIV_LIB   = 2'd3;

    localparam logic [31:0] PREV_RESTART_MS = 32'd3000;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_start;
        logic div_take;
        logic rd_issue;
        logic rd_take;
        logic commit;
    } tosu_cmd_t;

    typedef struct packed {
        logic [1:0] route;
        logic       div_done;
        logic       out_free;
    } tosu_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/tosu_divider.sv
// ---------------------------------------------------------------------------
// tosu_divider
// restoring serial remainder unit, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module tosu_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [15:0]      remainder
);

    localparam int STEPS = 32;
    localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  count_reg;
    logic [31:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] div_reg;

    logic [16:0] trial;
    logic        fits;
    logic [15:0] rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[31]};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? 16'(trial - {1'b0, div_reg}) : trial[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end else if (busy_reg) begin
                count_reg <= count_reg + 5'd1;
                if (count_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tosu_datapath.sv
// ---------------------------------------------------------------------------
// tosu_datapath
// play state, queue memory, choice logic, remainder unit and result register
// ---------------------------------------------------------------------------
`default_nettype none

`include "track_order_sequencer_unit_assert.svh"

module tosu_datapath #(
    parameter int QUEUE_DEPTH = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic [2:0]           s_mode,
    input  wire logic [15:0]          s_track,
    input  wire logic [7:0]           s_start_pos,
    input  wire logic                 s_last_entry,
    input  wire logic [31:0]          s_played_ms,
    input  wire logic [31:0]          s_random_word,
    input  wire tosu_pkg::tosu_cmd_t  cmd,
    output tosu_pkg::tosu_status_t    status,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output logic [1:0]                m_action,
    output logic [15:0]               m_chosen_track,
    output logic [16:0]               m_shown_position
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);

    // configuration
    logic [1:0]  repeat_reg;
    logic        shuffle_reg;
    logic [15:0] library_reg;

    // captured word
    logic [2:0]  in_mode_reg;
    logic [15:0] in_track_reg;
    logic [7:0]  in_start_reg;
    logic        in_last_reg;
    logic [31:0] in_elapsed_reg;
    logic [31:0] in_random_reg;

    // play state
    logic [LW-1:0] len_reg;
    logic [AW-1:0] pos_reg;
    logic [15:0]   cur_reg;
    logic          playing_reg;
    logic          load_open_reg;

    // per-word working state
    logic [15:0] nx_reg;
    logic [1:0]  act_reg;
    logic        eot_reg;
    logic [1:0]  route_reg;
    logic [15:0] rd_data_reg;

    // queue memory
    logic [15:0] qmem [QUEUE_DEPTH];

    // result register
    logic        m_valid_reg;
    logic [1:0]  m_action_reg;
    logic [15:0] m_chosen_reg;
    logic [16:0] m_shown_reg;

    // choice logic
    logic [1:0]    rep_eff;
    logic          fwd;
    logic [LW-1:0] len_app;
    logic [LW-1:0] qpos_ext;
    logic [LW-1:0] qbase;
    logic          q_ok;
    logic [16:0]   lbase;
    logic [15:0]   lib_nx;

    logic [LW-1:0] len_eval;
    logic [AW-1:0] pos_eval;
    logic [15:0]   nx_eval;
    logic [1:0]    act_eval;
    logic          playing_eval;
    logic          load_open_eval;
    logic          eot_eval;
    logic [1:0]    route_eval;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    logic          stop_now;
    logic [16:0]   shown_next;

    logic          div_done;
    logic [15:0]   div_rem;
    logic [15:0]   div_divisor;

    always_comb begin
        rep_eff  = (repeat_reg == tosu_pkg::REP_BAD) ? tosu_pkg::REP_OFF : repeat_reg;
        fwd      = in_mode_reg != tosu_pkg::MODE_PREV;
        len_app  = load_open_reg ? len_reg : '0;
        qpos_ext = LW'(pos_reg);

        // queue step
        q_ok = 1'b1;
        if (!fwd && pos_reg == '0) begin
            qbase = (rep_eff == tosu_pkg::REP_ALL) ? len_reg - LW'(1) : '0;
        end else begin
            qbase = fwd ? qpos_ext + LW'(1) : qpos_ext - LW'(1);
            if (qbase >= len_reg) begin
                q_ok  = rep_eff == tosu_pkg::REP_ALL;
                qbase = '0;
            end
        end

        // library step
        lbase = '0;
        if (!fwd && cur_reg == '0) begin
            lib_nx = (rep_eff == tosu_pkg::REP_ALL) ? library_reg - 16'd1 : '0;
        end else begin
            lbase = fwd ? {1'b0, cur_reg} + 17'd1 : {1'b0, cur_reg} - 17'd1;
            if (lbase >= {1'b0, library_reg}) begin
                lib_nx = (rep_eff == tosu_pkg::REP_ALL) ? '0 : cur_reg;
            end else begin
                lib_nx = lbase[15:0];
            end
        end
    end

    always_comb begin
        len_eval       = len_reg;
        pos_eval       = pos_reg;
        nx_eval        = cur_reg;
        act_eval       = tosu_pkg::ACT_NONE;
        playing_eval   = playing_reg;
        load_open_eval = load_open_reg;
        eot_eval       = 1'b0;
        route_eval     = tosu_pkg::ROUTE_DIRECT;
        wr_en          = 1'b0;
        wr_addr        = len_app[AW-1:0];

        unique case (in_mode_reg)
            tosu_pkg::MODE_APPEND: begin
                len_eval = len_app;
                if (len_app < DEPTH_L) begin
                    wr_en    = 1'b1;
                    len_eval = len_app + LW'(1);
                end
                load_open_eval = !in_last_reg;
                if (in_last_reg) begin
                    pos_eval     = (16'(in_start_reg) < 16'(len_eval)) ? AW'(in_start_reg) : '0;
                    playing_eval = 1'b1;
                    act_eval     = tosu_pkg::ACT_OPEN;
                    route_eval   = tosu_pkg::ROUTE_READ;
                end
            end
            tosu_pkg::MODE_PICK: begin
                len_eval       = '0;
                load_open_eval = 1'b0;
                nx_eval        = in_track_reg;
                playing_eval   = 1'b1;
                act_eval       = tosu_pkg::ACT_OPEN;
            end
            tosu_pkg::MODE_NEXT, tosu_pkg::MODE_PREV, tosu_pkg::MODE_EOT: begin
                if (playing_reg) begin
                    act_eval = tosu_pkg::ACT_OPEN;
                    eot_eval = in_mode_reg == tosu_pkg::MODE_EOT;
                    priority if (in_mode_reg == tosu_pkg::MODE_PREV &&
                                 in_elapsed_reg > tosu_pkg::PREV_RESTART_MS) begin
                        nx_eval = cur_reg;
                    end else if (rep_eff == tosu_pkg::REP_ONE) begin
                        nx_eval = cur_reg;
                    end else if (len_reg != '0) begin
                        if (shuffle_reg) begin
                            route_eval = tosu_pkg::ROUTE_DIV_QUEUE;
                        end else if (q_ok) begin
                            pos_eval   = qbase[AW-1:0];
                            route_eval = tosu_pkg::ROUTE_READ;
                        end
                    end else if (library_reg == '0) begin
                        nx_eval = '0;
                    end else if (shuffle_reg) begin
                        route_eval = tosu_pkg::ROUTE_DIV_LIB;
                    end else begin
                        nx_eval = lib_nx;
                    end
                end
            end
            tosu_pkg::MODE_STOP: begin
                if (playing_reg) begin
                    playing_eval = 1'b0;
                    act_eval     = tosu_pkg::ACT_STOP;
                end
            end
            default: begin
            end
        endcase
    end

    assign div_divisor = (route_eval == tosu_pkg::ROUTE_DIV_QUEUE) ? 16'(len_reg) : library_reg;

    tosu_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (in_random_reg),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // end of track stops when the choice did not move and repeat is off
    assign stop_now   = eot_reg && (nx_reg == cur_reg) && (rep_eff == tosu_pkg::REP_OFF);
    assign shown_next = (len_reg != '0) ? 17'(pos_reg) + 17'd1 : {1'b0, nx_reg} + 17'd1;

    // configuration and play state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_reg    <= tosu_pkg::REP_OFF;
            shuffle_reg   <= 1'b0;
            library_reg   <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            cur_reg       <= '0;
            playing_reg   <= 1'b0;
            load_open_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    tosu_pkg::CFG_REPEAT:  repeat_reg  <= cfg_data[1:0];
                    tosu_pkg::CFG_SHUFFLE: shuffle_reg <= cfg_data[0];
                    tosu_pkg::CFG_LIBRARY: library_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (cmd.eval) begin
                len_reg       <= len_eval;
                pos_reg       <= pos_eval;
                playing_reg   <= playing_eval;
                load_open_reg <= load_open_eval;
            end
            if (cmd.div_take && route_reg == tosu_pkg::ROUTE_DIV_QUEUE) begin
                pos_reg <= div_rem[AW-1:0];
            end
            if (cmd.commit) begin
                cur_reg <= nx_reg;
                if (stop_now) begin
                    playing_reg <= 1'b0;
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // captured word, working values and result payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_mode_reg    <= s_mode;
            in_track_reg   <= s_track;
            in_start_reg   <= s_start_pos;
            in_last_reg    <= s_last_entry;
            in_elapsed_reg <= s_played_ms;
            in_random_reg  <= s_random_word;
        end
        if (cmd.eval) begin
            nx_reg    <= nx_eval;
            act_reg   <= act_eval;
            eot_reg   <= eot_eval;
            route_reg <= route_eval;
        end
        if (cmd.div_take && route_reg == tosu_pkg::ROUTE_DIV_LIB) begin
            nx_reg <= div_rem;
        end
        if (cmd.rd_take) begin
            nx_reg <= rd_data_reg;
        end
        if (cmd.commit) begin
            m_action_reg <= stop_now ? tosu_pkg::ACT_STOP : act_reg;
            m_chosen_reg <= nx_reg;
            m_shown_reg  <= shown_next;
        end
    end

    // queue memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.eval && wr_en) begin
            qmem[wr_addr] <= in_track_reg;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= qmem[pos_reg];
        end
    end

    assign status.route    = route_eval;
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_action         = m_action_reg;
    assign m_chosen_track   = m_chosen_reg;
    assign m_shown_position = m_shown_reg;

    `TOSU_ASSERT_NEXT(a_commit_fills_output, aclk, aresetn, cmd.commit, m_valid_reg)
    `TOSU_ASSERT_IMPLY(a_len_in_range, aclk, aresetn, 1'b1, len_reg <= DEPTH_L)
    `TOSU_ASSERT_IMPLY(a_read_inside_queue, aclk, aresetn, cmd.rd_issue, qpos_ext < len_reg)

endmodule

`default_nettype wire

>>> hw/rtl/tosu_controller.sv
// ---------------------------------------------------------------------------
// tosu_controller
// sequences one event word through choice, remainder, queue read and result
// ---------------------------------------------------------------------------
`default_nettype none

`include "track_order_sequencer_unit_assert.svh"

module tosu_controller (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire tosu_pkg::tosu_status_t status,
    output tosu_pkg::tosu_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_DIVIDE = 3'd2;
    localparam logic [2:0] ST_RDADDR = 3'd3;
    localparam logic [2:0] ST_RDDATA = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       div_queue_reg;
    logic       div_queue_next;

    always_comb begin
        state_next     = state_reg;
        div_queue_next = div_queue_reg;
        cmd            = '0;
        s_ready        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                unique case (status.route)
                    tosu_pkg::ROUTE_DIRECT: state_next = ST_COMMIT;
                    tosu_pkg::ROUTE_READ:   state_next = ST_RDADDR;
                    tosu_pkg::ROUTE_DIV_QUEUE, tosu_pkg::ROUTE_DIV_LIB: begin
                        cmd.div_start  = 1'b1;
                        div_queue_next = status.route == tosu_pkg::ROUTE_DIV_QUEUE;
                        state_next     = ST_DIVIDE;
                    end
                    default: state_next = ST_COMMIT;
                endcase
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    cmd.div_take = 1'b1;
                    state_next   = div_queue_reg ? ST_RDADDR : ST_COMMIT;
                end
            end
            ST_RDADDR: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RDDATA;
            end
            ST_RDDATA: begin
                cmd.rd_take = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_queue_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_queue_reg <= div_queue_next;
        end
    end

    `TOSU_ASSERT_NEXT(a_accept_to_eval, aclk, aresetn, s_valid && s_ready, state_reg == ST_EVAL)
    `TOSU_ASSERT_IMPLY(a_done_in_divide, aclk, aresetn, status.div_done, state_reg == ST_DIVIDE)
    `TOSU_ASSERT_NEXT(a_commit_to_idle, aclk, aresetn, cmd.commit, state_reg == ST_IDLE)

endmodule

`default_nettype wire

>>> hw/rtl/track_order_sequencer_unit.sv
// ---------------------------------------------------------------------------
// track_order_sequencer_unit
// picks the next track from a loaded play queue or the library
// ---------------------------------------------------------------------------
// Each event word (append, direct pick, next, previous, end of track, stop)
// gives exactly one result word: an action (open, stop, no change), the
// current track and the one-based shown position. Event words are taken one
// at a time: after accept a word is evaluated and then goes to commit
// directly, through a queue read (address, then data), through the 32-step
// serial remainder unit (library, when shuffle is on), or through that unit
// and then a queue read (queue, when shuffle is on); the remainder unit
// gives one quotient bit per cycle. Commit loads the result register once
// the output is free, and the controller then returns to idle, where the
// next word can be accepted, also while a result still waits in the output
// register. The queue memory holds QUEUE_DEPTH entries and has no clearing
// pass; only entries written by the current load are ever read.
// Configuration writes are always ready and should only be issued while no
// event word is in flight.
`default_nettype none

module track_order_sequencer_unit #(
    parameter int QUEUE_DEPTH = 256     // queue entries, 1 to 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    // event words in
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_mode,
    input  wire logic [15:0] s_track,
    input  wire logic [7:0]  s_start_pos,
    input  wire logic        s_last_entry,
    input  wire logic [31:0] s_played_ms,
    input  wire logic [31:0] s_random_word,

    // result words out
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_action,
    output logic [15:0]      m_chosen_track,
    output logic [16:0]      m_shown_position
);

    // command and status between sequencer and datapath
    tosu_pkg::tosu_cmd_t    cmd;
    tosu_pkg::tosu_status_t status;

    // registers take any write at once
    assign cfg_ready = 1'b1;

    // state machine: capture, choose, divide, read queue, commit
    tosu_controller u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // play state, queue memory, remainder unit, result register
    tosu_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_mode           (s_mode),
        .s_track          (s_track),
        .s_start_pos      (s_start_pos),
        .s_last_entry     (s_last_entry),
        .s_played_ms      (s_played_ms),
        .s_random_word    (s_random_word),
        .cmd              (cmd),
        .status           (status),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_action         (m_action),
        .m_chosen_track   (m_chosen_track),
        .m_shown_position (m_shown_position)
    );

endmodule

`default_nettype wire
